### rtl/core/olfbd_pkg.sv
// Shared types and constants for the ordered list with front/back insert and delete by value.
// No dependencies; every module of the block imports this package.
package olfbd_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_DELETE     = 2'd2,
      OP_READ_OUT   = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      op_code_type               operation;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  element;
      logic                      last;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // Per-cell command
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_WRITE,
      CELL_MATCH,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        tail;      // first free position
      logic        wrap;      // last occupied position
      logic        occupied;
   } cell_ctrl_type;

endpackage

### rtl/core/ordered_list_front_back_delete_top.sv
// Ordered list of signed 32-bit values held in a chain of cells (olfbd_cell), uses olfbd_pkg.
// Insert: result registered and strobed in the cycle after the transfer, a new item every cycle.
// Delete: cells register their match flags, then shift in the next cycle (S_DELETE, busy) as the result is registered.
// Read out: one element per cycle as the chain rotates, busy until the last one (not at all if empty).
// Synchronous reset empties the list and idles the controller; cell contents are not cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
module ordered_list_front_back_delete_top
   import olfbd_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DELETE,
      S_READ
   } state_type;

   state_type           state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept;
   logic                full;
   logic                found;
   logic [FILL_W-1:0]   fill_last;
   cell_op_type         cell_op;

   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic                cell_hit  [CAPACITY];

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign full       = (fill_ff == FILL_W'(CAPACITY));
   assign found      = cell_hit[CAPACITY-1];
   assign fill_last  = fill_ff - FILL_W'(1);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Broadcast command to the chain
   always_comb begin
      cell_op = CELL_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_PUSH_FRONT: if (!full) cell_op = CELL_PUSH;
                  OP_PUSH_BACK:  if (!full) cell_op = CELL_WRITE;
                  OP_DELETE:     cell_op = CELL_MATCH;
                  OP_READ_OUT:   cell_op = CELL_HOLD;
                  default:       cell_op = CELL_HOLD;
               endcase
            end
         end
         S_DELETE: cell_op = CELL_DELETE;
         S_READ:   cell_op = CELL_ROTATE;
         default:  cell_op = CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;
      logic              hit_in;

      assign ctrl.op       = cell_op;
      assign ctrl.tail     = (fill_ff == FILL_W'(i));
      assign ctrl.wrap     = (fill_last == FILL_W'(i));
      assign ctrl.occupied = (FILL_W'(i) < fill_ff);

      if (i == 0) begin : g_head
         assign left_data = req_data.value;
         assign hit_in    = 1'b0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign hit_in    = cell_hit[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_data = cell_data[i];
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      olfbd_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key        (req_data.value),
         .left_data  (left_data),
         .right_data (right_data),
         .first_data (cell_data[0]),
         .hit_in     (hit_in),
         .data       (cell_data[i]),
         .hit_out    (cell_hit[i])
      );
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in.element = '0;
               rsp_in.last    = 1'b1;
               rsp_in.status  = ST_DONE;
               unique case (req_data.operation)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  OP_DELETE: begin
                     state_in = S_DELETE;
                  end
                  OP_READ_OUT: begin
                     if (fill_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_READ;
                        idx_in   = '0;
                     end
                  end
                  default: ;
               endcase
               rsp_in.count = COUNT_W'(fill_in);
            end
         end
         S_DELETE: begin
            rsp_strobe_in  = 1'b1;
            rsp_in.element = '0;
            rsp_in.last    = 1'b1;
            priority if (fill_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (found) begin
               rsp_in.status = ST_DONE;
               fill_in       = fill_ff - FILL_W'(1);
            end else begin
               rsp_in.status = ST_NOT_FOUND;
            end
            rsp_in.count = COUNT_W'(fill_in);
            state_in     = S_IDLE;
         end
         S_READ: begin
            // emit the head, the chain rotates underneath
            rsp_strobe_in  = 1'b1;
            rsp_in.status  = ST_DONE;
            rsp_in.element = cell_data[0];
            rsp_in.last    = (idx_ff == fill_last);
            rsp_in.count   = COUNT_W'(fill_ff);
            idx_in         = idx_ff + FILL_W'(1);
            if (idx_ff == fill_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/core/olfbd_cell.sv
// One storage cell of the list chain: holds an element and its match flag.
// Depends on olfbd_pkg for the cell command struct.
module olfbd_cell
   import olfbd_pkg::*;
(
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [DATA_W-1:0]    key,
   input  logic [DATA_W-1:0]    left_data,
   input  logic [DATA_W-1:0]    right_data,
   input  logic [DATA_W-1:0]    first_data,
   input  logic                 hit_in,
   output logic [DATA_W-1:0]    data,
   output logic                 hit_out
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              match_ff, match_in;

   // a cell at or behind the first match takes its right neighbor on delete
   assign hit_out = hit_in | match_ff;
   assign data    = data_ff;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      unique case (ctrl.op)
         CELL_HOLD:   ;
         CELL_PUSH:   data_in = left_data;
         CELL_WRITE:  if (ctrl.tail) data_in = key;
         CELL_MATCH:  match_in = ctrl.occupied && (data_ff == key);
         CELL_DELETE: if (hit_out) data_in = right_data;
         CELL_ROTATE: data_in = ctrl.wrap ? first_data : right_data;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

endmodule

### tb/testbench.sv
// Self-checking testbench for ordered_list_front_back_delete_top: directed table, then random ops.
// Depends on olfbd_pkg and the RTL of the block; a built-in list model predicts all results but those of typed rows.
`timescale 1ns / 1ps

module testbench;
   import olfbd_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int RANDOM_OPS  = 136;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   ordered_list_front_back_delete_top #(.CAPACITY(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Directed table; rows with typed set carry their single result in st and cnt.
   typedef struct {
      op_code_type op;
      logic [31:0] value;
      int          reps;
      bit          typed;
      status_type  st;
      int          cnt;
   } stim_row_type;

   localparam int NUM_ROWS = 22;
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{OP_READ_OUT,   32'h0000_0000,  1, 1'b1, ST_EMPTY,      0},
      '{OP_DELETE,     32'h0000_0000,  1, 1'b1, ST_EMPTY,      0},
      '{OP_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, ST_DONE,       1},
      '{OP_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, ST_DONE,       2},
      '{OP_PUSH_BACK,  32'h0000_0000,  1, 1'b1, ST_DONE,       3},
      '{OP_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, ST_DONE,       4},
      '{OP_DELETE,     32'h0000_0005,  1, 1'b1, ST_NOT_FOUND,  4},
      '{OP_READ_OUT,   32'h0000_0000,  1, 1'b0, ST_DONE,       0},
      '{OP_DELETE,     32'h8000_0000,  1, 1'b1, ST_DONE,       3},
      '{OP_PUSH_FRONT, 32'h0000_0001,  1, 1'b1, ST_DONE,       4},
      '{OP_PUSH_BACK,  32'h0000_0001,  1, 1'b1, ST_DONE,       5},
      '{OP_DELETE,     32'h0000_0001,  1, 1'b1, ST_DONE,       4},
      '{OP_DELETE,     32'hFFFF_FFFF,  1, 1'b1, ST_DONE,       3},
      '{OP_READ_OUT,   32'h0000_0000,  1, 1'b0, ST_DONE,       0},
      '{OP_PUSH_BACK,  32'h5555_AAAA, 13, 1'b0, ST_DONE,       0},
      '{OP_PUSH_FRONT, 32'h1234_5678,  1, 1'b1, ST_FULL,      16},
      '{OP_PUSH_BACK,  32'hAAAA_5555,  1, 1'b1, ST_FULL,      16},
      '{OP_READ_OUT,   32'h0000_0000,  1, 1'b0, ST_DONE,       0},
      '{OP_DELETE,     32'h5555_AAAA,  1, 1'b1, ST_DONE,      15},
      '{OP_DELETE,     32'h7FFF_FFFF,  1, 1'b1, ST_DONE,      14},
      '{OP_DELETE,     32'h7FFF_FFFF,  1, 1'b1, ST_NOT_FOUND, 14},
      '{OP_READ_OUT,   32'h0000_0000,  1, 1'b0, ST_DONE,       0}
   };

   // List model
   logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
   int                       list_fill = 0;
   rsp_type                  step_results [$];
   rsp_type                  pending_results [$];
   rsp_type                  oldest_result;

   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int miss_hits = 0;
   int cycle_count = 0;

   function automatic rsp_type make_result(status_type st, logic signed [DATA_W-1:0] el,
                                           logic lst);
      rsp_type r;
      r.status  = st;
      r.element = el;
      r.last    = lst;
      r.count   = COUNT_W'(list_fill);
      return r;
   endfunction

   task automatic list_apply(input req_type r);
      status_type st;
      int pos;
      st = ST_DONE;
      step_results.delete();
      case (r.operation)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (list_fill >= LIST_DEPTH) begin
               st = ST_FULL;
               full_hits++;
            end else if (r.operation == OP_PUSH_FRONT) begin
               for (int i = list_fill; i > 0; i--) list_mem[i] = list_mem[i-1];
               list_mem[0] = r.value;
               list_fill++;
            end else begin
               list_mem[list_fill] = r.value;
               list_fill++;
            end
            step_results.push_back(make_result(st, '0, 1'b1));
         end
         OP_DELETE: begin
            if (list_fill == 0) begin
               st = ST_EMPTY;
               empty_hits++;
            end else begin
               pos = list_fill;
               // scan from the back so the frontmost match wins
               for (int i = list_fill - 1; i >= 0; i--)
                  if (list_mem[i] == r.value) pos = i;
               if (pos == list_fill) begin
                  st = ST_NOT_FOUND;
                  miss_hits++;
               end else begin
                  for (int i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
                  list_fill--;
               end
            end
            step_results.push_back(make_result(st, '0, 1'b1));
         end
         default: begin
            if (list_fill == 0) begin
               empty_hits++;
               step_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end else begin
               for (int i = 0; i < list_fill; i++)
                  step_results.push_back(make_result(ST_DONE, list_mem[i],
                                                     (i == list_fill - 1)));
            end
         end
      endcase
   endtask

   // Hold start until the block takes the transfer, then log what it should produce.
   task automatic transfer_item(input req_type r, input bit typed, input status_type st,
                                input int cnt);
      rsp_type typed_result;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      list_apply(r);
      if (typed) begin
         typed_result.status  = st;
         typed_result.element = '0;
         typed_result.last    = 1'b1;
         typed_result.count   = COUNT_W'(cnt);
         pending_results.push_back(typed_result);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
      items_sent++;
   endtask

   task automatic idle_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start    <= 1'b0;
         req_data <= req_type'({$urandom, $urandom});
         @(posedge clock);
      end
   endtask

   // Values: mostly a small pool so deletes hit and duplicates occur, plus extremes and noise.
   logic [31:0] value_pool [8];

   function automatic logic [31:0] pick_value(input bit for_delete);
      int sel;
      sel = $urandom_range(99);
      if (for_delete && list_fill > 0 && sel < 55)
         return list_mem[$urandom_range(list_fill - 1)];
      if (sel < 70) return value_pool[$urandom_range(7)];
      if (sel < 85) return $urandom;
      case ($urandom_range(3))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   function automatic op_code_type pick_op(input bit growing);
      int sel;
      sel = $urandom_range(99);
      if (growing) begin
         if (sel < 40) return OP_PUSH_FRONT;
         if (sel < 72) return OP_PUSH_BACK;
         if (sel < 90) return OP_DELETE;
         return OP_READ_OUT;
      end
      if (sel < 15) return OP_PUSH_FRONT;
      if (sel < 30) return OP_PUSH_BACK;
      if (sel < 82) return OP_DELETE;
      return OP_READ_OUT;
   endfunction

   initial begin
      req_type r;
      int idle_pct;
      bit growing;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         for (int n = 0; n < directed_rows[k].reps; n++) begin
            r.operation = directed_rows[k].op;
            r.value     = directed_rows[k].value;
            transfer_item(r, directed_rows[k].typed, directed_rows[k].st,
                          directed_rows[k].cnt);
         end
      end

      foreach (value_pool[i]) value_pool[i] = $urandom;
      growing = 1'b0;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n < 40)       idle_pct = 0;
         else if (n < 80)  idle_pct = 86;
         else if (n < 115) idle_pct = 6;
         else              idle_pct = 0;
         // swing between filling and draining so both full and empty get reached
         if (n % 25 == 0) growing = !growing;
         if (n % 40 == 39) value_pool[$urandom_range(7)] = $urandom;
         r.operation = pick_op(growing);
         r.value     = pick_value(r.operation == OP_DELETE);
         transfer_item(r, 1'b0, ST_DONE, 0);
         idle_gap(idle_pct);
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Ran %0d list ops (directed table, then random with idle phases 0/86/6 pct);",
               items_sent);
      $display("checked %0d results; full %0d, empty %0d, not-found %0d cases.",
               results_checked, full_hits, empty_hits, miss_hits);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result check: every strobe must match the oldest pending result.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_data);
            errors++;
         end else begin
            oldest_result = pending_results.pop_front();
            results_checked++;
            if (rsp_data.status !== oldest_result.status) begin
               $display("%0t: status expected %s actual %0d", $time,
                        oldest_result.status.name(), rsp_data.status);
               errors++;
            end
            if (rsp_data.element !== oldest_result.element) begin
               $display("%0t: element expected %0d actual %0d", $time,
                        oldest_result.element, rsp_data.element);
               errors++;
            end
            if (rsp_data.last !== oldest_result.last) begin
               $display("%0t: last expected %0b actual %0b", $time,
                        oldest_result.last, rsp_data.last);
               errors++;
            end
            if (rsp_data.count !== oldest_result.count) begin
               $display("%0t: count expected %0d actual %0d", $time,
                        oldest_result.count, rsp_data.count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results pending", $time, pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
